// ----- design/pngsde_pkg.sv -----
// ----------------------------------------------------------------------------
// pngsde_pkg
// Shared types, constants and byte helpers of the PNG stored-deflate encoder.
// ----------------------------------------------------------------------------
package pngsde_pkg;

   localparam int          MAX_SIDE_DEF = 4096;
   localparam int          CSR_W        = 13;
   localparam int          QDEPTH       = 4;
   localparam logic [12:0] SIDE_RESET   = 13'd64;

   localparam logic [15:0] BLOCK_MAX   = 16'hFFFF;
   localparam logic [16:0] ADLER_MOD   = 17'd65521;
   localparam logic [31:0] CRC_POLY    = 32'hEDB88320;
   localparam logic [31:0] CRC_INIT    = 32'hFFFFFFFF;
   localparam logic [7:0]  ZLIB_CMF    = 8'h78;
   localparam logic [7:0]  ZLIB_FLG    = 8'h01;
   localparam logic [7:0]  IHDR_DEPTH  = 8'd8;
   localparam logic [7:0]  IHDR_COLOR  = 8'd6;
   localparam logic [31:0] IHDR_LEN    = 32'd13;
   localparam logic [31:0] TYPE_IHDR   = 32'h49484452;
   localparam logic [31:0] TYPE_IDAT   = 32'h49444154;
   localparam logic [31:0] TYPE_IEND   = 32'h49454E44;

   typedef struct packed {
      logic first;
      logic row_start;
      logic last;
   } pngsde_flags_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_HEAD,
      S_IDAT,
      S_RAW,
      S_BLK,
      S_TAIL
   } pngsde_state_type;

   typedef enum logic [1:0] {
      CRC_HOLD,
      CRC_START,
      CRC_UPD
   } pngsde_crc_op_type;

   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'd0, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
      end
      return c;
   endfunction

   // Byte i (0 = most significant) of a 32-bit word.
   function automatic logic [7:0] be_byte(input logic [31:0] v, input logic [1:0] i);
      logic [7:0] b;
      case (i)
         2'd0:    b = v[31:24];
         2'd1:    b = v[23:16];
         2'd2:    b = v[15:8];
         default: b = v[7:0];
      endcase
      return b;
   endfunction

   function automatic logic [7:0] sig_byte(input logic [2:0] i);
      logic [7:0] b;
      case (i)
         3'd0:    b = 8'h89;
         3'd1:    b = 8'h50;
         3'd2:    b = 8'h4E;
         3'd3:    b = 8'h47;
         3'd4:    b = 8'h0D;
         3'd5:    b = 8'h0A;
         3'd6:    b = 8'h1A;
         default: b = 8'h0A;
      endcase
      return b;
   endfunction

endpackage

// ----- design/pngsde_front.sv -----
// ----------------------------------------------------------------------------
// pngsde_front
// Pixel intake: holds the side register, tracks row and column, and tags
// each pixel as first of image, start of row or last of image.
// ----------------------------------------------------------------------------
module pngsde_front import pngsde_pkg::*; #(
   parameter int MAX_SIDE = MAX_SIDE_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_wr_en,
   input  logic [CSR_W-1:0]             csr_wr_data,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [7:0]                   req_red,
   input  logic [7:0]                   req_green,
   input  logic [7:0]                   req_blue,
   input  logic [7:0]                   req_alpha,
   input  logic                         q_full,
   output logic                         q_push,
   output logic [31:0]                  q_pix,
   output pngsde_flags_type             q_flags,
   output logic [$clog2(MAX_SIDE+1)-1:0] q_side
);

   localparam int SW = $clog2(MAX_SIDE+1);

   logic [CSR_W-1:0] side_cfg_ff, side_cfg_in;
   logic             in_img_ff, in_img_in;
   logic [SW-1:0]    act_side_ff, act_side_in;
   logic [SW-1:0]    col_ff, col_in;
   logic [SW-1:0]    row_ff, row_in;
   logic [SW-1:0]    cfg_side;
   logic [SW-1:0]    eff_side;
   logic             col_end;

   // Clamp the programmed side into 2..MAX_SIDE.
   always_comb begin
      if (32'(side_cfg_ff) > 32'(MAX_SIDE)) begin
         cfg_side = SW'(MAX_SIDE);
      end else if (side_cfg_ff < CSR_W'(2)) begin
         cfg_side = SW'(2);
      end else begin
         cfg_side = SW'(side_cfg_ff);
      end
   end

   assign eff_side  = in_img_ff ? act_side_ff : cfg_side;
   assign col_end   = (col_ff == eff_side - SW'(1));
   assign req_ready = !q_full;
   assign q_push    = req_valid && req_ready;
   assign q_pix     = {req_red, req_green, req_blue, req_alpha};
   assign q_side    = eff_side;

   always_comb begin
      q_flags.first     = !in_img_ff;
      q_flags.row_start = (col_ff == '0);
      q_flags.last      = col_end && (row_ff == eff_side - SW'(1));
   end

   always_comb begin
      side_cfg_in = csr_wr_en ? csr_wr_data : side_cfg_ff;
      in_img_in   = in_img_ff;
      act_side_in = act_side_ff;
      col_in      = col_ff;
      row_in      = row_ff;
      if (q_push) begin
         act_side_in = eff_side;
         in_img_in   = !q_flags.last;
         if (q_flags.last) begin
            col_in = '0;
            row_in = '0;
         end else if (col_end) begin
            col_in = '0;
            row_in = row_ff + SW'(1);
         end else begin
            col_in = col_ff + SW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_cfg_ff <= SIDE_RESET;
         in_img_ff   <= 1'b0;
         col_ff      <= '0;
         row_ff      <= '0;
      end else begin
         side_cfg_ff <= side_cfg_in;
         in_img_ff   <= in_img_in;
         col_ff      <= col_in;
         row_ff      <= row_in;
      end
      act_side_ff <= act_side_in;
   end

endmodule

// ----- design/pngsde_queue.sv -----
// ----------------------------------------------------------------------------
// pngsde_queue
// Short first-in first-out queue between intake and byte sequencer.
// ----------------------------------------------------------------------------
module pngsde_queue import pngsde_pkg::*; #(
   parameter int DATA_W = 8,
   parameter int DEPTH  = QDEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [DATA_W-1:0] push_data,
   input  logic              pop,
   output logic [DATA_W-1:0] pop_data,
   output logic              full,
   output logic              empty
);

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH+1);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [PW-1:0]     wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0]     count_ff;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PW'(DEPTH-1)) ? '0 : wr_ptr_ff + PW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PW'(DEPTH-1)) ? '0 : rd_ptr_ff + PW'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + CW'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- design/pngsde_back.sv -----
// ----------------------------------------------------------------------------
// pngsde_back
// Byte sequencer: emits headers, block headers, pixel bytes and trailers one
// byte per cycle unless stalled, with chunk CRC, Adler-32 and block counters.
// ----------------------------------------------------------------------------
module pngsde_back import pngsde_pkg::*; #(
   parameter int MAX_SIDE = MAX_SIDE_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          q_empty,
   input  logic [31:0]                   q_pix,
   input  pngsde_flags_type              q_flags,
   input  logic [$clog2(MAX_SIDE+1)-1:0] q_side,
   output logic                          q_pop,
   input  logic                          rsp_ready,
   output logic                          rsp_valid,
   output logic [7:0]                    rsp_out_byte,
   output logic                          rsp_last_of_run,
   output logic                          rsp_end_of_file
);

   localparam int SW = $clog2(MAX_SIDE+1);
   localparam int RW = $clog2((4*MAX_SIDE+1)*MAX_SIDE+1);

   localparam logic [5:0] HEAD_LAST = 6'd32;
   localparam logic [5:0] IDAT_LAST = 6'd9;
   localparam logic [5:0] RAW_LAST  = 6'd4;
   localparam logic [5:0] TAIL_LAST = 6'd19;
   localparam logic [2:0] BLK_LAST  = 3'd4;

   pngsde_state_type  state_ff, state_in;
   logic [5:0]        idx_ff, idx_in;
   logic [2:0]        bidx_ff, bidx_in;
   logic [31:0]       pix_ff, pix_in;
   pngsde_flags_type  flags_ff, flags_in;
   logic [SW-1:0]     side_ff, side_in;
   logic [RW-1:0]     raw_total_ff;
   logic [RW-1:0]     blocks_ff;
   logic [RW:0]       idat_len_ff;
   logic [RW-1:0]     raw_left_ff, raw_left_in;
   logic [15:0]       blk_left_ff, blk_left_in;
   logic [15:0]       adl_lo_ff, adl_lo_in;
   logic [15:0]       adl_hi_ff, adl_hi_in;
   logic [31:0]       crc_ff, crc_in;
   logic              rsp_valid_ff;
   logic [7:0]        out_byte_ff;
   logic              lor_ff, eof_ff;

   logic              adv, emit, raw_en, done, lor_c, eof_c;
   logic [7:0]        byte_c;
   pngsde_crc_op_type crc_op;
   logic [RW-1:0]     s_w, raw_calc;
   logic [RW+1:0]     div_x, div_q;
   logic [15:0]       blk_count;
   logic              blk_final;
   logic [16:0]       lo_sum, lo_new, hi_sum, hi_new;
   logic [31:0]       crc_out;

   // Totals of the image, settled long before the IDAT length is sent.
   assign s_w      = RW'(side_ff);
   assign raw_calc = ((s_w << 2) + RW'(1)) * s_w;
   // Ceiling divide by 65535 through the add-and-shift reciprocal.
   assign div_x    = (RW+2)'(raw_total_ff) + (RW+2)'(BLOCK_MAX - 16'd1);
   assign div_q    = (div_x + (div_x >> 16) + (RW+2)'(1)) >> 16;

   always_ff @(posedge clock) begin
      raw_total_ff <= raw_calc;
      blocks_ff    <= RW'(div_q);
      idat_len_ff  <= (RW+1)'(6) + ((RW+1)'(blocks_ff) << 2) + (RW+1)'(blocks_ff)
                      + (RW+1)'(raw_total_ff);
   end

   assign adv       = !rsp_valid_ff || rsp_ready;
   assign blk_final = (raw_left_ff <= RW'(BLOCK_MAX));
   assign blk_count = blk_final ? 16'(raw_left_ff) : BLOCK_MAX;
   assign crc_out   = crc_ff ^ CRC_INIT;

   always_comb begin
      lo_sum = {1'b0, adl_lo_ff} + {9'd0, byte_c};
      lo_new = (lo_sum >= ADLER_MOD) ? lo_sum - ADLER_MOD : lo_sum;
      hi_sum = {1'b0, adl_hi_ff} + lo_new;
      hi_new = (hi_sum >= ADLER_MOD) ? hi_sum - ADLER_MOD : hi_sum;
   end

   always_comb begin
      state_in    = state_ff;
      idx_in      = idx_ff;
      bidx_in     = bidx_ff;
      pix_in      = pix_ff;
      flags_in    = flags_ff;
      side_in     = side_ff;
      raw_left_in = raw_left_ff;
      blk_left_in = blk_left_ff;
      adl_lo_in   = adl_lo_ff;
      adl_hi_in   = adl_hi_ff;
      crc_in      = crc_ff;
      q_pop       = 1'b0;
      emit        = 1'b0;
      raw_en      = 1'b0;
      done        = 1'b0;
      lor_c       = 1'b0;
      eof_c       = 1'b0;
      byte_c      = 8'd0;
      crc_op      = CRC_HOLD;

      unique case (state_ff)
         S_IDLE: begin
            done = 1'b1;
         end
         S_HEAD: begin
            emit = 1'b1;
            case (idx_ff) inside
               [6'd0:6'd7]:   byte_c = sig_byte(idx_ff[2:0]);
               [6'd8:6'd11]: begin
                  byte_c = be_byte(IHDR_LEN, idx_ff[1:0]);
                  crc_op = CRC_START;
               end
               [6'd12:6'd15]: begin
                  byte_c = be_byte(TYPE_IHDR, idx_ff[1:0]);
                  crc_op = CRC_UPD;
               end
               [6'd16:6'd23]: begin
                  byte_c = be_byte(32'(side_ff), idx_ff[1:0]);
                  crc_op = CRC_UPD;
               end
               6'd24: begin
                  byte_c = IHDR_DEPTH;
                  crc_op = CRC_UPD;
               end
               6'd25: begin
                  byte_c = IHDR_COLOR;
                  crc_op = CRC_UPD;
               end
               [6'd26:6'd28]: crc_op = CRC_UPD;
               default:       byte_c = be_byte(crc_out, idx_ff[1:0] + 2'd3);
            endcase
            if (adv) begin
               idx_in = idx_ff + 6'd1;
               if (idx_ff == HEAD_LAST) begin
                  state_in = S_IDAT;
                  idx_in   = '0;
               end
            end
         end
         S_IDAT: begin
            emit = 1'b1;
            case (idx_ff) inside
               [6'd0:6'd3]: begin
                  byte_c = be_byte(32'(idat_len_ff), idx_ff[1:0]);
                  crc_op = CRC_START;
               end
               [6'd4:6'd7]: begin
                  byte_c = be_byte(TYPE_IDAT, idx_ff[1:0]);
                  crc_op = CRC_UPD;
               end
               6'd8: begin
                  byte_c = ZLIB_CMF;
                  crc_op = CRC_UPD;
               end
               default: begin
                  byte_c = ZLIB_FLG;
                  crc_op = CRC_UPD;
               end
            endcase
            if (adv) begin
               idx_in = idx_ff + 6'd1;
               if (idx_ff == IDAT_LAST) begin
                  state_in    = S_RAW;
                  idx_in      = flags_ff.row_start ? 6'd0 : 6'd1;
                  raw_left_in = raw_total_ff;
                  blk_left_in = '0;
                  adl_lo_in   = 16'd1;
                  adl_hi_in   = 16'd0;
               end
            end
         end
         S_RAW: begin
            if (blk_left_ff == '0) begin
               // Open a new stored block before the next raw byte.
               state_in = S_BLK;
               bidx_in  = '0;
            end else begin
               emit   = 1'b1;
               raw_en = 1'b1;
               crc_op = CRC_UPD;
               case (idx_ff)
                  6'd1:    byte_c = pix_ff[31:24];
                  6'd2:    byte_c = pix_ff[23:16];
                  6'd3:    byte_c = pix_ff[15:8];
                  6'd4:    byte_c = pix_ff[7:0];
                  default: byte_c = 8'd0;
               endcase
               if (idx_ff == RAW_LAST && !flags_ff.last) begin
                  lor_c = 1'b1;
                  done  = 1'b1;
               end
               if (adv) begin
                  idx_in = idx_ff + 6'd1;
                  if (idx_ff == RAW_LAST && flags_ff.last) begin
                     state_in = S_TAIL;
                     idx_in   = '0;
                  end
               end
            end
         end
         S_BLK: begin
            emit   = 1'b1;
            crc_op = CRC_UPD;
            case (bidx_ff)
               3'd0:    byte_c = {7'd0, blk_final};
               3'd1:    byte_c = blk_count[7:0];
               3'd2:    byte_c = blk_count[15:8];
               3'd3:    byte_c = ~blk_count[7:0];
               default: byte_c = ~blk_count[15:8];
            endcase
            if (adv) begin
               bidx_in = bidx_ff + 3'd1;
               if (bidx_ff == BLK_LAST) begin
                  blk_left_in = blk_count;
                  state_in    = S_RAW;
               end
            end
         end
         S_TAIL: begin
            emit = 1'b1;
            case (idx_ff) inside
               [6'd0:6'd3]: begin
                  byte_c = be_byte({adl_hi_ff, adl_lo_ff}, idx_ff[1:0]);
                  crc_op = CRC_UPD;
               end
               [6'd8:6'd11]:  crc_op = CRC_START;
               [6'd12:6'd15]: begin
                  byte_c = be_byte(TYPE_IEND, idx_ff[1:0]);
                  crc_op = CRC_UPD;
               end
               default:       byte_c = be_byte(crc_out, idx_ff[1:0]);
            endcase
            if (idx_ff == TAIL_LAST) begin
               lor_c = 1'b1;
               eof_c = 1'b1;
               done  = 1'b1;
            end
            if (adv) begin
               idx_in = idx_ff + 6'd1;
               if (idx_ff == TAIL_LAST) begin
                  raw_left_in = '0;
                  blk_left_in = '0;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (adv && emit) begin
         case (crc_op)
            CRC_START: crc_in = CRC_INIT;
            CRC_UPD:   crc_in = crc_byte(crc_ff, byte_c);
            default:   crc_in = crc_ff;
         endcase
      end

      if (adv && raw_en) begin
         adl_lo_in   = lo_new[15:0];
         adl_hi_in   = hi_new[15:0];
         raw_left_in = raw_left_ff - RW'(1);
         blk_left_in = blk_left_ff - 16'd1;
      end

      // Load the next queued pixel as this one finishes, or drop to idle.
      if (done && (adv || state_ff == S_IDLE)) begin
         if (!q_empty) begin
            q_pop    = 1'b1;
            pix_in   = q_pix;
            flags_in = q_flags;
            if (q_flags.first) begin
               side_in  = q_side;
               state_in = S_HEAD;
               idx_in   = '0;
            end else begin
               state_in = S_RAW;
               idx_in   = q_flags.row_start ? 6'd0 : 6'd1;
            end
         end else begin
            state_in = S_IDLE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         idx_ff       <= '0;
         bidx_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         raw_left_ff  <= '0;
         blk_left_ff  <= '0;
         adl_lo_ff    <= 16'd1;
         adl_hi_ff    <= 16'd0;
         crc_ff       <= CRC_INIT;
      end else begin
         state_ff    <= state_in;
         idx_ff      <= idx_in;
         bidx_ff     <= bidx_in;
         raw_left_ff <= raw_left_in;
         blk_left_ff <= blk_left_in;
         adl_lo_ff   <= adl_lo_in;
         adl_hi_ff   <= adl_hi_in;
         crc_ff      <= crc_in;
         if (adv) begin
            rsp_valid_ff <= emit;
         end
      end
      pix_ff   <= pix_in;
      flags_ff <= flags_in;
      side_ff  <= side_in;
      if (adv) begin
         out_byte_ff <= byte_c;
         lor_ff      <= lor_c;
         eof_ff      <= eof_c;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_byte    = out_byte_ff;
   assign rsp_last_of_run = lor_ff;
   assign rsp_end_of_file = eof_ff;

endmodule

// ----- design/png_stored_deflate_encoder_top.sv -----
// ----------------------------------------------------------------------------
// png_stored_deflate_encoder_top
// Streams a complete PNG file (IHDR, one IDAT of stored deflate blocks, IEND)
// for a square RGBA image delivered one pixel per transaction.
// ----------------------------------------------------------------------------
//
//   channel   ports        direction   moves
//   -------   ----------   ---------   -------------------------------------
//   req_      valid/ready  in          one RGBA pixel in raster order
//   rsp_      valid/ready  out         one file byte plus run and file flags
//   csr_      wr_en/data   in          image side, sampled at image start
//
// One byte leaves per cycle unless the output stalls or a block opens;
// a plain pixel yields 4 bytes (5 at a row start). The first pixel of an
// image adds 43 header bytes, the last adds 20 trailer bytes, and each stored
// block adds 5 header bytes. The pixel queue keeps intake running while the
// output stalls. Reset is synchronous; no clearing pass.
//
module png_stored_deflate_encoder_top import pngsde_pkg::*; #(
   parameter int MAX_SIDE = MAX_SIDE_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_wr_en,
   input  logic [CSR_W-1:0] csr_wr_data,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [7:0]       req_red,
   input  logic [7:0]       req_green,
   input  logic [7:0]       req_blue,
   input  logic [7:0]       req_alpha,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_last_of_run,
   output logic             rsp_end_of_file
);

   localparam int SW = $clog2(MAX_SIDE+1);
   localparam int QW = 32 + $bits(pngsde_flags_type) + SW;

   logic             q_push, q_pop, q_full, q_empty;
   logic [31:0]      f_pix, b_pix;
   pngsde_flags_type f_flags, b_flags;
   logic [SW-1:0]    f_side, b_side;
   logic [QW-1:0]    q_wdata, q_rdata;

   // Tag incoming pixels with their place in the image.
   pngsde_front #(.MAX_SIDE(MAX_SIDE)) u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_red     (req_red),
      .req_green   (req_green),
      .req_blue    (req_blue),
      .req_alpha   (req_alpha),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_pix       (f_pix),
      .q_flags     (f_flags),
      .q_side      (f_side)
   );

   assign q_wdata = {f_side, f_flags, f_pix};

   // Hold tagged pixels until the sequencer is ready for them.
   pngsde_queue #(.DATA_W(QW), .DEPTH(QDEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wdata),
      .pop       (q_pop),
      .pop_data  (q_rdata),
      .full      (q_full),
      .empty     (q_empty)
   );

   assign {b_side, b_flags, b_pix} = q_rdata;

   // Turn each pixel into its run of file bytes.
   pngsde_back #(.MAX_SIDE(MAX_SIDE)) u_back (
      .clock           (clock),
      .reset           (reset),
      .q_empty         (q_empty),
      .q_pix           (b_pix),
      .q_flags         (b_flags),
      .q_side          (b_side),
      .q_pop           (q_pop),
      .rsp_ready       (rsp_ready),
      .rsp_valid       (rsp_valid),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_last_of_run (rsp_last_of_run),
      .rsp_end_of_file (rsp_end_of_file)
   );

endmodule

// ----- design/pngsde_checker.sv -----
// ----------------------------------------------------------------------------
// pngsde_checker
// Port-level checks of the encoder's output transactions.
// ----------------------------------------------------------------------------
module pngsde_checker import pngsde_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_last_of_run,
   input logic       rsp_end_of_file
);

   // A file always ends where a pixel's run ends.
   a_eof_ends_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_end_of_file |-> rsp_last_of_run)
      else $error("end of file without end of run");

   // The IEND CRC is fixed, so the final file byte is always its low byte.
   a_eof_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_end_of_file |-> rsp_out_byte == 8'h82)
      else $error("final byte is not the IEND CRC tail");

   // A file never ends twice in a row: the IEND chunk alone is twelve bytes.
   a_eof_spacing: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_end_of_file |=> !(rsp_valid && rsp_end_of_file))
      else $error("back-to-back end of file");

   a_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte))
      else $error("stalled response changed");

endmodule

bind png_stored_deflate_encoder_top pngsde_checker u_pngsde_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_out_byte    (rsp_out_byte),
   .rsp_last_of_run (rsp_last_of_run),
   .rsp_end_of_file (rsp_end_of_file)
);
